// ===== rtl/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_pkg
// Shared widths, header bit positions, packet bundle and delta decoding for
// the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package pmt_pkg;

   localparam int BYTE_W          = 8;
   localparam int CFG_W           = 12;
   localparam int POS_W           = 12;
   localparam int MAX_COORD_BITS  = 16;
   localparam int DELTA_W         = 10;
   localparam int CSR_INDEX_W     = 2;
   localparam int RSP_DATA_W      = 32;
   localparam int RSP_FIELDS_W    = 2 * POS_W + 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_HEIGHT = 2'd1;

   // header bit positions
   localparam int HDR_LEFT   = 0;
   localparam int HDR_RIGHT  = 1;
   localparam int HDR_MIDDLE = 2;
   localparam int HDR_ALIGN  = 3;
   localparam int HDR_XSIGN  = 4;
   localparam int HDR_YSIGN  = 5;
   localparam int HDR_XOVF   = 6;
   localparam int HDR_YOVF   = 7;

   // reset values, cut down to the coordinate width where they are used
   localparam logic [MAX_COORD_BITS-1:0] RESET_SCREEN_WIDTH  = 16'd1024;
   localparam logic [MAX_COORD_BITS-1:0] RESET_SCREEN_HEIGHT = 16'd768;
   localparam logic [MAX_COORD_BITS-1:0] RESET_CURSOR_X      = 16'd512;
   localparam logic [MAX_COORD_BITS-1:0] RESET_CURSOR_Y      = 16'd384;

   localparam logic signed [DELTA_W-1:0] OVF_STEP = 10'sd255;

   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] x_byte;
      logic [BYTE_W-1:0] y_byte;
   } packet_type;

   // 9-bit two's complement delta, pushed a further 255 along its sign on overflow
   function automatic logic signed [DELTA_W-1:0] decode_delta(
      input logic [BYTE_W-1:0] low,
      input logic              neg,
      input logic              ovf
   );
      logic signed [DELTA_W-1:0] d;
      d = $signed({neg, neg, low});
      if (ovf) begin
         if (neg) begin
            d = d - OVF_STEP;
         end else begin
            d = d + OVF_STEP;
         end
      end
      return d;
   endfunction

endpackage

// ===== rtl/ps2_mouse_packet_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Groups PS/2 mouse bytes into three-byte packets, moves a clamped cursor and
// reports the position and buttons once per complete packet.
// ----------------------------------------------------------------------------
//
//   port group   direction   payload
//   csr_*        in          csr_index (register), csr_data (12-bit value)
//   req_*        in          data_byte
//   rsp_*        out         pos_x, pos_y, left, middle, right buttons
//
// One request is taken per cycle while req_tready is high; a packet's result appears
// in the output register the cycle after its third byte is taken.
// req_tready is low only while a result sits unclaimed and rsp_tready is low.
// Reset puts the cursor at 512,384 and the screen at 1024 by 768, and arms
// the drop of the first byte. csr_ready is always high.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker
   import pmt_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]       csr_data,

   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] data_byte

   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [11:0] pos_x, [23:12] pos_y, [24] left_button, [25] middle_button,
   // [26] right_button, rest zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_XBYTE,
      PH_YBYTE
   } phase_type;

   phase_type                 phase_ff;
   phase_type                 phase_in;
   logic                      skip_first_ff;
   logic [BYTE_W-1:0]         header_ff;
   logic [BYTE_W-1:0]         header_in;
   logic [BYTE_W-1:0]         x_byte_ff;
   logic [BYTE_W-1:0]         x_byte_in;
   logic [COORD_BITS-1:0]     cursor_x_ff;
   logic [COORD_BITS-1:0]     cursor_y_ff;
   logic [COORD_BITS-1:0]     width_ff;
   logic [COORD_BITS-1:0]     height_ff;
   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_in;

   logic                      req_fire;
   logic                      csr_fire;
   logic                      packet_done;
   logic [MAX_COORD_BITS-1:0] csr_value;
   logic [COORD_BITS-1:0]     next_x;
   logic [COORD_BITS-1:0]     next_y;
   logic [MAX_COORD_BITS-1:0] pos_x_ext;
   logic [MAX_COORD_BITS-1:0] pos_y_ext;
   packet_type                pkt;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid & csr_ready;
   assign csr_value  = MAX_COORD_BITS'(csr_data);

   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign req_fire   = req_tvalid & req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign pkt.header = header_ff;
   assign pkt.x_byte = x_byte_ff;
   assign pkt.y_byte = req_tdata;

   pmt_cursor_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .pkt      (pkt),
      .cursor_x (cursor_x_ff),
      .cursor_y (cursor_y_ff),
      .limit_x  (width_ff),
      .limit_y  (height_ff),
      .next_x   (next_x),
      .next_y   (next_y)
   );

   always_comb begin
      phase_in    = phase_ff;
      header_in   = header_ff;
      x_byte_in   = x_byte_ff;
      packet_done = 1'b0;
      unique case (phase_ff)
         PH_XBYTE: begin
            x_byte_in = req_tdata;
            phase_in  = PH_YBYTE;
         end
         PH_YBYTE: begin
            packet_done = 1'b1;
            phase_in    = PH_HEADER;
         end
         default: begin
            // drop bytes that cannot be a header to regain alignment
            if (req_tdata[HDR_ALIGN]) begin
               header_in = req_tdata;
               phase_in  = PH_XBYTE;
            end else begin
               phase_in  = PH_HEADER;
            end
         end
      endcase
   end

   always_comb begin
      pos_x_ext   = MAX_COORD_BITS'(next_x);
      pos_y_ext   = MAX_COORD_BITS'(next_y);
      rsp_data_in = RSP_DATA_W'({header_ff[HDR_RIGHT], header_ff[HDR_MIDDLE],
                                 header_ff[HDR_LEFT], pos_y_ext[POS_W-1:0],
                                 pos_x_ext[POS_W-1:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= RESET_SCREEN_WIDTH[COORD_BITS-1:0];
         height_ff     <= RESET_SCREEN_HEIGHT[COORD_BITS-1:0];
         skip_first_ff <= 1'b1;
         phase_ff      <= PH_HEADER;
         header_ff     <= '0;
         x_byte_ff     <= '0;
         cursor_x_ff   <= RESET_CURSOR_X[COORD_BITS-1:0];
         cursor_y_ff   <= RESET_CURSOR_Y[COORD_BITS-1:0];
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_fire) begin
            unique case (csr_index)
               CSR_SCREEN_WIDTH:  width_ff  <= csr_value[COORD_BITS-1:0];
               CSR_SCREEN_HEIGHT: height_ff <= csr_value[COORD_BITS-1:0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (req_fire) begin
            if (skip_first_ff) begin
               skip_first_ff <= 1'b0;
            end else begin
               phase_ff  <= phase_in;
               header_ff <= header_in;
               x_byte_ff <= x_byte_in;
               if (packet_done) begin
                  cursor_x_ff  <= next_x;
                  cursor_y_ff  <= next_y;
                  rsp_valid_ff <= 1'b1;
               end
            end
         end
      end
   end

   // result payload, held while the result waits on rsp_tready
   always_ff @(posedge clock) begin
      if (req_fire && !skip_first_ff && packet_done) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== rtl/pmt_cursor_step.sv =====
// ----------------------------------------------------------------------------
// pmt_cursor_step
// Applies the decoded packet deltas to the cursor and clamps the result to
// the screen limits. Purely combinational.
// ----------------------------------------------------------------------------
module pmt_cursor_step
   import pmt_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  packet_type            pkt,
   input  logic [COORD_BITS-1:0] cursor_x,
   input  logic [COORD_BITS-1:0] cursor_y,
   input  logic [COORD_BITS-1:0] limit_x,
   input  logic [COORD_BITS-1:0] limit_y,
   output logic [COORD_BITS-1:0] next_x,
   output logic [COORD_BITS-1:0] next_y
);

   localparam int SUM_W = ((COORD_BITS > DELTA_W) ? COORD_BITS : DELTA_W) + 2;

   logic signed [DELTA_W-1:0] dx;
   logic signed [DELTA_W-1:0] dy;
   logic signed [SUM_W-1:0]   sum_x;
   logic signed [SUM_W-1:0]   sum_y;

   always_comb begin
      dx = decode_delta(pkt.x_byte, pkt.header[HDR_XSIGN], pkt.header[HDR_XOVF]);
      dy = decode_delta(pkt.y_byte, pkt.header[HDR_YSIGN], pkt.header[HDR_YOVF]);
      // screen Y grows downwards
      sum_x = $signed(SUM_W'(cursor_x)) + SUM_W'(dx);
      sum_y = $signed(SUM_W'(cursor_y)) - SUM_W'(dy);
   end

   always_comb begin
      if (sum_x < 0) begin
         next_x = '0;
      end else if (sum_x > $signed(SUM_W'(limit_x))) begin
         next_x = limit_x;
      end else begin
         next_x = sum_x[COORD_BITS-1:0];
      end

      if (sum_y < 0) begin
         next_y = '0;
      end else if (sum_y > $signed(SUM_W'(limit_y))) begin
         next_y = limit_y;
      end else begin
         next_y = sum_y[COORD_BITS-1:0];
      end
   end

endmodule
